FILE: rtl/core/psg_pkg.sv
`timescale 1ns / 1ps

package psg_pkg;

  // Generator clock divider default and register file geometry.
  localparam int unsigned PRESCALE_DEF = 8;
  localparam int unsigned NUM_REGS     = 16;
  localparam int unsigned NUM_CH       = 3;

  // Item operation codes.
  typedef enum logic [1:0] {
    OP_SELECT = 2'd0,
    OP_WRITE  = 2'd1,
    OP_TICK   = 2'd2
  } psg_op_e;

  // Sound register numbers with side effects or fixed readers.
  localparam logic [3:0] REG_NOISE_PERIOD = 4'd6;
  localparam logic [3:0] REG_MIXER        = 4'd7;
  localparam logic [3:0] REG_VOL_A        = 4'd8;
  localparam logic [3:0] REG_ENV_FINE     = 4'd11;
  localparam logic [3:0] REG_ENV_COARSE   = 4'd12;
  localparam logic [3:0] REG_ENV_SHAPE    = 4'd13;

  // Counter reset values and noise feedback taps. The top tap sits one bit
  // above the 17-bit shift register and lands in its top bit after the shift.
  localparam logic [15:0] TONE_CNT_RST   = 16'h1000;
  localparam logic [15:0] NOISE_CNT_RST  = 16'h0040;
  localparam logic [16:0] NOISE_LFSR_RST = 17'h0FFFF;
  localparam logic [17:0] NOISE_TAPS     = 18'h24000;
  localparam logic [31:0] ENV_WRAP       = 32'h0001_0000;

  // Envelope mode flags.
  typedef struct packed {
    logic cont;
    logic alt;
    logic hold;
    logic face;
    logic pause;
  } env_flags_t;

  // Controller states.
  typedef enum logic [1:0] {
    ST_IDLE,
    ST_ENV,
    ST_DONE
  } psg_state_e;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic exec;
    logic env_step;
    logic load_levels;
    logic push;
  } psg_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic gen_tick;
    logic env_due;
    logic out_free;
  } psg_status_t;

  // Logarithmic volume table.
  function automatic logic [7:0] level_lut(input logic [4:0] idx);
    logic [7:0] lvl;
    case (idx)
      5'd0:  lvl = 8'h00;
      5'd1:  lvl = 8'h01;
      5'd2:  lvl = 8'h01;
      5'd3:  lvl = 8'h02;
      5'd4:  lvl = 8'h02;
      5'd5:  lvl = 8'h03;
      5'd6:  lvl = 8'h03;
      5'd7:  lvl = 8'h04;
      5'd8:  lvl = 8'h05;
      5'd9:  lvl = 8'h06;
      5'd10: lvl = 8'h07;
      5'd11: lvl = 8'h09;
      5'd12: lvl = 8'h0B;
      5'd13: lvl = 8'h0D;
      5'd14: lvl = 8'h0F;
      5'd15: lvl = 8'h12;
      5'd16: lvl = 8'h16;
      5'd17: lvl = 8'h1A;
      5'd18: lvl = 8'h1F;
      5'd19: lvl = 8'h25;
      5'd20: lvl = 8'h2D;
      5'd21: lvl = 8'h35;
      5'd22: lvl = 8'h3F;
      5'd23: lvl = 8'h4C;
      5'd24: lvl = 8'h5A;
      5'd25: lvl = 8'h6A;
      5'd26: lvl = 8'h7F;
      5'd27: lvl = 8'h97;
      5'd28: lvl = 8'hB4;
      5'd29: lvl = 8'hD6;
      5'd30: lvl = 8'hEB;
      default: lvl = 8'hFF;
    endcase
    return lvl;
  endfunction

endpackage

FILE: rtl/core/three_channel_psg_sound_generator.sv
`timescale 1ns / 1ps
// Channel  Direction  Handshake                 Beat contents
// in       input      in_valid_i / in_ready_o   operation_i, data_i
// out      output     out_valid_o / out_ready_i level_a_o, level_b_o, level_c_o, mix_sum_o
//
// A select, a write or a tick that does not clock the generator runs IDLE then DONE.
// A tick that clocks the generator runs IDLE, ENV and DONE, and ENV makes one envelope
// step per period held in the envelope counter, one step per cycle; the counter
// normally holds 0 or 1 periods.
// Async reset puts all but the output payload registers at their initial values.
// A result waits in the output register; the block takes the next beat while it waits,
// and stalls in its final cycle only while the output register is still full.

module three_channel_psg_sound_generator #(
  parameter int unsigned PRESCALE = psg_pkg::PRESCALE_DEF
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_ready_o,
  input  logic [1:0] operation_i,
  input  logic [7:0] data_i,
  output logic       out_valid_o,
  input  logic       out_ready_i,
  output logic [7:0] level_a_o,
  output logic [7:0] level_b_o,
  output logic [7:0] level_c_o,
  output logic [9:0] mix_sum_o
);
  import psg_pkg::*;

  psg_cmd_t    cmd;
  psg_status_t status;

  // Sequencer.
  psg_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .status_i   (status),
    .cmd_o      (cmd)
  );

  // Registers, generators and output register.
  psg_dp #(
    .PRESCALE (PRESCALE)
  ) u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_i       (cmd),
    .status_o    (status),
    .operation_i (operation_i),
    .data_i      (data_i),
    .out_ready_i (out_ready_i),
    .out_valid_o (out_valid_o),
    .level_a_o   (level_a_o),
    .level_b_o   (level_b_o),
    .level_c_o   (level_c_o),
    .mix_sum_o   (mix_sum_o)
  );

endmodule

FILE: rtl/core/psg_ctrl.sv
`timescale 1ns / 1ps

module psg_ctrl (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  output logic                 in_ready_o,
  input  psg_pkg::psg_status_t status_i,
  output psg_pkg::psg_cmd_t    cmd_o
);
  import psg_pkg::*;

  psg_state_e state_q, state_d;

  // State register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // Next state and commands.
  always_comb begin
    state_d    = state_q;
    in_ready_o = 1'b0;
    cmd_o      = '0;
    case (state_q)
      ST_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.exec = 1'b1;
          state_d    = status_i.gen_tick ? ST_ENV : ST_DONE;
        end
      end
      ST_ENV: begin
        // One envelope step per cycle while counter >= wrap point and period != 0.
        if (status_i.env_due) begin
          cmd_o.env_step = 1'b1;
        end else begin
          cmd_o.load_levels = 1'b1;
          state_d           = ST_DONE;
        end
      end
      ST_DONE: begin
        if (status_i.out_free) begin
          cmd_o.push = 1'b1;
          state_d    = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

endmodule

FILE: rtl/core/psg_dp.sv
`timescale 1ns / 1ps

module psg_dp #(
  parameter int unsigned PRESCALE = psg_pkg::PRESCALE_DEF
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  psg_pkg::psg_cmd_t    cmd_i,
  output psg_pkg::psg_status_t status_o,
  input  logic [1:0]           operation_i,
  input  logic [7:0]           data_i,
  input  logic                 out_ready_i,
  output logic                 out_valid_o,
  output logic [7:0]           level_a_o,
  output logic [7:0]           level_b_o,
  output logic [7:0]           level_c_o,
  output logic [9:0]           mix_sum_o
);
  import psg_pkg::*;

  localparam int unsigned PsW = (PRESCALE > 1) ? $clog2(PRESCALE) : 1;

  // Architectural state.
  logic [3:0]       sel_q;
  logic [7:0]       sound_q [NUM_REGS];
  logic [PsW-1:0]   ps_q;
  logic [15:0]      tone_cnt_q [NUM_CH];
  logic [NUM_CH-1:0] tone_ph_q;
  logic [15:0]      noise_cnt_q;
  logic [16:0]      lfsr_q;
  logic [5:0]       noise_per_q;
  logic [31:0]      env_cnt_q;
  logic [5:0]       env_pos_q;
  env_flags_t       env_flags_q;
  logic [7:0]       lvl_q [NUM_CH];

  // Output register.
  logic             out_valid_q;
  logic [7:0]       out_lvl_q [NUM_CH];
  logic [9:0]       out_sum_q;

  // Next-value logic.
  logic [15:0]      env_per;
  logic [PsW:0]     ps_inc;
  logic             gen_tick;
  logic [15:0]      noise_inc;
  logic [15:0]      noise_cnt_d;
  logic [16:0]      lfsr_d;
  logic [15:0]      tone_cnt_d [NUM_CH];
  logic [NUM_CH-1:0] tone_ph_d;
  logic [7:0]       lvl_d [NUM_CH];
  logic [10:0]      env_step_d;
  env_flags_t       shape_flags;

  // One step of the envelope shape.
  function automatic logic [10:0] env_next(input env_flags_t f_in, input logic [5:0] pos_in);
    env_flags_t f;
    logic [5:0] pos;
    f   = f_in;
    pos = pos_in;
    if (!f.pause) begin
      pos = f.face ? pos + 6'd1 : pos - 6'd1;
    end
    if (pos[5]) begin
      if (f.cont) begin
        if (f.alt != f.hold) begin
          f.face = !f.face;
        end
        if (f.hold) begin
          f.pause = 1'b1;
        end
        pos = f.face ? 6'd0 : 6'h1F;
      end else begin
        f.pause = 1'b1;
        pos     = 6'd0;
      end
    end
    return {f, pos};
  endfunction

  assign env_per    = {sound_q[REG_ENV_COARSE], sound_q[REG_ENV_FINE]};
  assign ps_inc     = {1'b0, ps_q} + {{PsW{1'b0}}, 1'b1};
  assign gen_tick   = (operation_i == OP_TICK) && (ps_inc >= (PsW + 1)'(PRESCALE));
  assign env_step_d = env_next(env_flags_q, env_pos_q);

  // Status toward the controller.
  assign status_o.gen_tick = gen_tick;
  assign status_o.env_due  = (env_cnt_q[31:16] != 16'd0) && (env_per != 16'd0);
  assign status_o.out_free = !out_valid_q || out_ready_i;

  // Envelope shape register decode.
  always_comb begin
    shape_flags       = '0;
    shape_flags.cont  = data_i[3];
    shape_flags.face  = data_i[2];
    shape_flags.alt   = data_i[1];
    shape_flags.hold  = data_i[0];
  end

  // Noise counter and shift register.
  always_comb begin
    noise_inc   = noise_cnt_q + 16'd1;
    noise_cnt_d = noise_inc;
    lfsr_d      = lfsr_q;
    if (noise_inc[6]) begin
      lfsr_d      = 17'(({1'b0, lfsr_q} ^ (lfsr_q[0] ? NOISE_TAPS : 18'd0)) >> 1);
      noise_cnt_d = noise_inc - {10'd0, noise_per_q};
    end
  end

  // Tone lanes and channel level lookup.
  for (genvar ch = 0; ch < NUM_CH; ch++) begin : g_ch
    logic [11:0] tper;
    logic [15:0] tinc;
    logic [7:0]  vreg;
    logic [4:0]  vidx;
    logic        gate;

    assign tper = {sound_q[2*ch+1][3:0], sound_q[2*ch]};
    assign tinc = tone_cnt_q[ch] + 16'd1;
    assign vreg = sound_q[REG_VOL_A + ch];
    assign vidx = vreg[4] ? env_pos_q[4:0] : {vreg[3:0], 1'b0};
    assign gate = (sound_q[REG_MIXER][ch] || tone_ph_q[ch]) &&
                  (sound_q[REG_MIXER][ch+3] || lfsr_q[0]);

    always_comb begin
      tone_cnt_d[ch] = tinc;
      tone_ph_d[ch]  = tone_ph_q[ch];
      if (tinc[12]) begin
        if (tper > 12'd1) begin
          tone_ph_d[ch]  = !tone_ph_q[ch];
          tone_cnt_d[ch] = tinc - {4'd0, tper};
        end else begin
          tone_ph_d[ch] = 1'b1;
        end
      end
    end

    assign lvl_d[ch] = gate ? level_lut(vidx) : 8'd0;
  end

  // Generator state updates.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sel_q       <= '0;
      for (int i = 0; i < NUM_REGS; i++) begin
        sound_q[i] <= '0;
      end
      ps_q        <= '0;
      for (int i = 0; i < NUM_CH; i++) begin
        tone_cnt_q[i] <= TONE_CNT_RST;
        lvl_q[i]      <= '0;
      end
      tone_ph_q   <= '0;
      noise_cnt_q <= NOISE_CNT_RST;
      lfsr_q      <= NOISE_LFSR_RST;
      noise_per_q <= '0;
      env_cnt_q   <= '0;
      env_pos_q   <= '0;
      env_flags_q <= '{cont: 1'b0, alt: 1'b0, hold: 1'b0, face: 1'b0, pause: 1'b1};
    end else begin
      if (cmd_i.exec) begin
        case (operation_i)
          OP_SELECT: begin
            sel_q <= data_i[3:0];
          end
          OP_WRITE: begin
            sound_q[sel_q] <= data_i;
            if (sel_q == REG_NOISE_PERIOD) begin
              noise_per_q <= (data_i == 8'd0) ? 6'd1 : {data_i[4:0], 1'b0};
            end
            if (sel_q == REG_ENV_SHAPE) begin
              env_flags_q <= shape_flags;
              env_cnt_q   <= ENV_WRAP - {16'd0, env_per};
              env_pos_q   <= data_i[2] ? 6'd0 : 6'h1F;
            end
          end
          OP_TICK: begin
            if (gen_tick) begin
              ps_q        <= '0;
              env_cnt_q   <= env_cnt_q + 32'd1;
              noise_cnt_q <= noise_cnt_d;
              lfsr_q      <= lfsr_d;
              tone_ph_q   <= tone_ph_d;
              for (int i = 0; i < NUM_CH; i++) begin
                tone_cnt_q[i] <= tone_cnt_d[i];
              end
            end else begin
              ps_q <= ps_inc[PsW-1:0];
            end
          end
          default: begin
          end
        endcase
      end
      // Envelope catch-up, one period per step.
      if (cmd_i.env_step) begin
        {env_flags_q, env_pos_q} <= env_step_d;
        env_cnt_q                <= env_cnt_q - {16'd0, env_per};
      end
      if (cmd_i.load_levels) begin
        for (int i = 0; i < NUM_CH; i++) begin
          lvl_q[i] <= lvl_d[i];
        end
      end
    end
  end

  // Output beat valid flag.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.push) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  // Output beat payload.
  always_ff @(posedge clk_i) begin
    if (cmd_i.push) begin
      for (int i = 0; i < NUM_CH; i++) begin
        out_lvl_q[i] <= lvl_q[i];
      end
      out_sum_q <= {2'd0, lvl_q[0]} + {2'd0, lvl_q[1]} + {2'd0, lvl_q[2]};
    end
  end

  assign out_valid_o = out_valid_q;
  assign level_a_o   = out_lvl_q[0];
  assign level_b_o   = out_lvl_q[1];
  assign level_c_o   = out_lvl_q[2];
  assign mix_sum_o   = out_sum_q;

endmodule

FILE: rtl/core/psg_checker.sv
`timescale 1ns / 1ps

module psg_checker (
  input logic       clk_i,
  input logic       rst_ni,
  input logic       in_valid_i,
  input logic       in_ready_o,
  input logic [1:0] operation_i,
  input logic [7:0] data_i,
  input logic       out_valid_o,
  input logic       out_ready_i,
  input logic [7:0] level_a_o,
  input logic [7:0] level_b_o,
  input logic [7:0] level_c_o,
  input logic [9:0] mix_sum_o
);

  // A stalled output beat keeps its payload.
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(level_a_o) &&
      $stable(level_b_o) && $stable(level_c_o) && $stable(mix_sum_o))
    else $error("output beat changed while stalled");

  // The mix is the sum of the three levels.
  a_mix_sum: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> mix_sum_o == ({2'd0, level_a_o} + {2'd0, level_b_o} + {2'd0, level_c_o}))
    else $error("mix sum does not match channel levels");

  // An accepted beat keeps the input closed for at least the next cycle.
  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o |=> !in_ready_o)
    else $error("input ready right after an accepted beat");

  // A new result appears only out of a busy cycle.
  a_result_from_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_o) |-> !$past(in_ready_o))
    else $error("result appeared without work in progress");

  // Operation and data are only observed through the handshake.
  logic unused_in;
  assign unused_in = ^{operation_i, data_i};

endmodule

bind three_channel_psg_sound_generator psg_checker u_psg_checker (.*);
